FILE: rtl/fcpa_pkg.sv
// Shared types and codes for the fixed chunk pool allocator.
package fcpa_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned BASE_W     = 32;
    localparam int unsigned SIZE_W     = 16;
    localparam int unsigned COUNT_W    = 9;
    localparam int unsigned FIELD_AW   = 32;

    localparam logic [BASE_W-1:0]  BASE_RESET  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 16'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE  = 2'd0,
        REG_SIZE  = 2'd1,
        REG_COUNT = 2'd2
    } t_reg_idx;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_GRANTED      = 2'd0,
        ST_EMPTY        = 2'd1,
        ST_PUT_OK       = 2'd2,
        ST_PUT_REJECTED = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                command;
        logic [FIELD_AW-1:0] chunk_address;
    } t_cmd_in;

    typedef struct packed {
        t_status             status;
        logic [FIELD_AW-1:0] granted_address;
        logic [COUNT_W-1:0]  free_count;
    } t_result;

endpackage

FILE: rtl/fcpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcpa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fcpa_range.sv
// Put address range check: base <= addr < base + count*size.
module fcpa_range #(
    parameter int unsigned CNT_W = 9
) (
    input  logic                        i_clk,
    input  logic [CNT_W-1:0]            i_eff_count,
    input  logic [fcpa_pkg::SIZE_W-1:0] i_chunk_size,
    input  logic [fcpa_pkg::BASE_W-1:0] i_base,
    input  logic [fcpa_pkg::FIELD_AW-1:0] i_addr,
    output logic                        o_in_range
);

    localparam int unsigned SPAN_W = CNT_W + fcpa_pkg::SIZE_W;
    localparam int unsigned CMP_W  = (SPAN_W > fcpa_pkg::BASE_W) ? SPAN_W : fcpa_pkg::BASE_W;

    // span is registered from the config registers; the user must keep commands
    // from reaching the check before span has caught up after a write, the block itself does not enforce it
    logic [SPAN_W-1:0]           r_span;
    logic [fcpa_pkg::BASE_W-1:0] offset;

    always_ff @(posedge i_clk) begin
        r_span <= SPAN_W'(i_eff_count) * SPAN_W'(i_chunk_size);
    end

    assign offset     = fcpa_pkg::BASE_W'(i_addr) - i_base;
    assign o_in_range = (fcpa_pkg::BASE_W'(i_addr) >= i_base)
                        && (CMP_W'(offset) < CMP_W'(r_span));

endmodule

FILE: rtl/fixed_chunk_pool_allocator.sv
// Top level: fixed-size chunk pool with a FIFO free list held in RAM.
//
//  channel   direction  handshake           payload
//  command   in         start & !busy       i_cmd    (t_cmd_in)
//  result    out        o_valid, one cycle  o_result (t_result)
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_wdata
//
// For each command the accept edge reads the free-list RAM at the take slot, and
// the next cycle evaluates, writes back a put and registers the result.
// o_valid is high in the cycle after that; busy is high during the evaluate cycle.
// Reset is synchronous; no RAM clearing pass: a fill count marks written slots,
// unwritten ones read as their initial address from a running register.
// Results cannot be stalled; a config write to a valid index restarts the pool.
module fixed_chunk_pool_allocator #(
    parameter int unsigned POOL_DEPTH   = 256,
    parameter int unsigned ADDRESS_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fcpa_pkg::t_cmd_in               i_cmd,
    output logic                            o_valid,
    output fcpa_pkg::t_result               o_result,
    input  logic                            i_cfg_we,
    input  logic [fcpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fcpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned IDX_W = $clog2(POOL_DEPTH);
    localparam int unsigned CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int unsigned AW    = ADDRESS_BITS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [fcpa_pkg::BASE_W-1:0]  r_base, n_base;
    logic [fcpa_pkg::SIZE_W-1:0]  r_size, n_size;
    logic [fcpa_pkg::COUNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0]             r_eff, n_eff;

    logic [IDX_W-1:0] r_take, n_take;
    logic [IDX_W-1:0] r_ret, n_ret;
    logic [CNT_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [AW-1:0]    r_take_addr, n_take_addr;

    fcpa_pkg::t_cmd_in r_item;
    fcpa_pkg::t_result r_result, n_result;
    logic              r_valid, n_valid;

    logic          accept;
    logic          cfg_hit;
    logic          in_range;
    logic [AW-1:0] ram_rdata;
    logic          ram_we;
    logic [CNT_W-1:0] take_inc;
    logic [CNT_W-1:0] ret_inc;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_EXEC);

    fcpa_ram #(
        .WIDTH (AW),
        .DEPTH (POOL_DEPTH)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ret),
        .i_wdata (AW'(r_item.chunk_address)),
        .i_raddr (r_take),
        .o_rdata (ram_rdata)
    );

    fcpa_range #(
        .CNT_W (CNT_W)
    ) u_range (
        .i_clk        (i_clk),
        .i_eff_count  (r_eff),
        .i_chunk_size (r_size),
        .i_base       (r_base),
        .i_addr       (r_item.chunk_address),
        .o_in_range   (in_range)
    );

    assign take_inc = CNT_W'(r_take) + CNT_W'(1);
    assign ret_inc  = CNT_W'(r_ret) + CNT_W'(1);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_size      = r_size;
        n_count     = r_count;
        n_eff       = r_eff;
        n_take      = r_take;
        n_ret       = r_ret;
        n_free      = r_free;
        n_fill      = r_fill;
        n_take_addr = r_take_addr;
        n_result    = r_result;
        n_valid     = 1'b0;
        ram_we      = 1'b0;
        cfg_hit     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_valid  = 1'b1;
                n_result.granted_address = '0;
                if (r_item.command == fcpa_pkg::CMD_GET) begin
                    if ((r_free == '0) || (r_eff == '0) || (CNT_W'(r_take) >= r_eff)) begin
                        n_result.status = fcpa_pkg::ST_EMPTY;
                    end else begin
                        n_result.status = fcpa_pkg::ST_GRANTED;
                        n_result.granted_address = (CNT_W'(r_take) < r_fill)
                            ? fcpa_pkg::FIELD_AW'(ram_rdata)
                            : fcpa_pkg::FIELD_AW'(r_take_addr);
                        n_free = r_free - CNT_W'(1);
                        if (take_inc >= r_eff) begin
                            n_take      = '0;
                            n_take_addr = AW'(r_base);
                        end else begin
                            n_take      = IDX_W'(take_inc);
                            n_take_addr = r_take_addr + AW'(r_size);
                        end
                    end
                end else begin
                    if (in_range && (r_free < r_eff) && (CNT_W'(r_ret) < r_eff)) begin
                        n_result.status = fcpa_pkg::ST_PUT_OK;
                        ram_we = 1'b1;
                        n_free = r_free + CNT_W'(1);
                        n_ret  = (ret_inc >= r_eff) ? '0 : IDX_W'(ret_inc);
                        if (r_fill < r_eff) begin
                            n_fill = r_fill + CNT_W'(1);
                        end
                    end else begin
                        n_result.status = fcpa_pkg::ST_PUT_REJECTED;
                    end
                end
                n_result.free_count = fcpa_pkg::COUNT_W'(n_free);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // user must keep config writes idle-only; any valid index restarts the pool
        if (i_cfg_we) begin
            case (i_cfg_idx)
                fcpa_pkg::REG_BASE: begin
                    n_base  = fcpa_pkg::BASE_W'(i_cfg_wdata);
                    cfg_hit = 1'b1;
                end
                fcpa_pkg::REG_SIZE: begin
                    n_size  = fcpa_pkg::SIZE_W'(i_cfg_wdata);
                    cfg_hit = 1'b1;
                end
                fcpa_pkg::REG_COUNT: begin
                    n_count = fcpa_pkg::COUNT_W'(i_cfg_wdata);
                    cfg_hit = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        if (cfg_hit) begin
            n_eff = (32'(n_count) > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : CNT_W'(n_count);
            n_take      = '0;
            n_ret       = '0;
            n_fill      = '0;
            n_free      = n_eff;
            n_take_addr = AW'(n_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= fcpa_pkg::BASE_RESET;
            r_size      <= fcpa_pkg::SIZE_RESET;
            r_count     <= fcpa_pkg::COUNT_RESET;
            r_eff       <= (32'(fcpa_pkg::COUNT_RESET) > POOL_DEPTH)
                           ? CNT_W'(POOL_DEPTH) : CNT_W'(fcpa_pkg::COUNT_RESET);
            r_free      <= (32'(fcpa_pkg::COUNT_RESET) > POOL_DEPTH)
                           ? CNT_W'(POOL_DEPTH) : CNT_W'(fcpa_pkg::COUNT_RESET);
            r_take      <= '0;
            r_ret       <= '0;
            r_fill      <= '0;
            r_take_addr <= AW'(fcpa_pkg::BASE_RESET);
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_size      <= n_size;
            r_count     <= n_count;
            r_eff       <= n_eff;
            r_free      <= n_free;
            r_take      <= n_take;
            r_ret       <= n_ret;
            r_fill      <= n_fill;
            r_take_addr <= n_take_addr;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_cmd;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // every accepted command is followed by the busy cycle and then a result strobe
    a_cmd_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy ##1 o_valid))
        else $error("command did not produce a result");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free <= r_eff) && (r_fill <= r_eff))
        else $error("free or fill count above pool size");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EXEC))
        else $error("result without a command in flight");

    a_grant_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (n_result.status == fcpa_pkg::ST_GRANTED) && !i_cfg_we)
        |=> (r_free == $past(r_free) - CNT_W'(1)))
        else $error("grant did not consume a chunk");

endmodule

FILE: tb/sv/tb_fixed_chunk_pool_allocator.sv
// Self-checking testbench for the fixed chunk pool allocator: directed and random commands.
module tb_fixed_chunk_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POOL_SLOTS  = 256;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RAND_PHASES = 8;
    localparam int unsigned PHASE_ITEMS = 69;
    localparam logic [fcpa_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic                            busy;
    fcpa_pkg::t_cmd_in               i_cmd       = '0;
    logic                            o_valid;
    fcpa_pkg::t_result               o_result;
    logic                            i_cfg_we    = 1'b0;
    logic [fcpa_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [fcpa_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    fixed_chunk_pool_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Pool model state
    logic [fcpa_pkg::BASE_W-1:0]  pool_base  = fcpa_pkg::BASE_RESET;
    logic [fcpa_pkg::SIZE_W-1:0]  pool_size  = fcpa_pkg::SIZE_RESET;
    logic [fcpa_pkg::COUNT_W-1:0] pool_count = fcpa_pkg::COUNT_RESET;
    logic [31:0]                  slot_addr  [POOL_SLOTS];
    bit                           slot_valid [POOL_SLOTS];
    int unsigned                  take_idx;
    int unsigned                  give_idx;
    int unsigned                  free_now;

    fcpa_pkg::t_cmd_in cmd_pending[$];
    fcpa_pkg::t_result result_expect[$];
    bit                cmd_taken;
    int unsigned       idle_pct;
    int unsigned       err_count;
    int unsigned       cycle_count;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned live_chunks();
        return (pool_count > fcpa_pkg::COUNT_W'(POOL_SLOTS)) ? POOL_SLOTS : int'(pool_count);
    endfunction

    function automatic void restart_pool();
        for (int i = 0; i < POOL_SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_addr[i]  = '0;
        end
        take_idx = 0;
        give_idx = 0;
        free_now = live_chunks();
    endfunction

    function automatic fcpa_pkg::t_result apply_command(fcpa_pkg::t_cmd_in c);
        fcpa_pkg::t_result r;
        int unsigned       n;
        logic [31:0]       first_addr;
        n = live_chunks();
        r = '0;
        if (c.command == fcpa_pkg::CMD_GET) begin
            if (free_now == 0 || n == 0 || take_idx >= n) begin
                r.status = fcpa_pkg::ST_EMPTY;
            end else begin
                // never-written slot still holds its initial address, wrapped to 32 bits
                first_addr = pool_base + take_idx * pool_size;
                r.status = fcpa_pkg::ST_GRANTED;
                r.granted_address = slot_valid[take_idx] ? slot_addr[take_idx] : first_addr;
                take_idx = (take_idx + 1 >= n) ? 0 : take_idx + 1;
                free_now--;
            end
        end else if (c.chunk_address >= pool_base &&
                     64'(c.chunk_address - pool_base) < 64'(n) * 64'(pool_size) &&
                     free_now < n && give_idx < n) begin
            slot_addr[give_idx]  = c.chunk_address;
            slot_valid[give_idx] = 1'b1;
            give_idx = (give_idx + 1 >= n) ? 0 : give_idx + 1;
            free_now++;
            r.status = fcpa_pkg::ST_PUT_OK;
        end else begin
            r.status = fcpa_pkg::ST_PUT_REJECTED;
        end
        r.free_count = free_now[fcpa_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic void push_get(logic [31:0] addr);
        fcpa_pkg::t_cmd_in c;
        c.command       = fcpa_pkg::CMD_GET;
        c.chunk_address = addr;
        cmd_pending.push_back(c);
    endfunction

    function automatic void push_put(logic [31:0] addr);
        fcpa_pkg::t_cmd_in c;
        c.command       = fcpa_pkg::CMD_PUT;
        c.chunk_address = addr;
        cmd_pending.push_back(c);
    endfunction

    // Mostly gets and in-range puts; some chunk-aligned edges, some garbage addresses.
    function automatic void push_random(int unsigned count);
        longint unsigned span;
        int unsigned     r;
        span = 64'(live_chunks()) * 64'(pool_size);
        repeat (count) begin
            r = $urandom_range(99);
            if (r < 45) begin
                push_get($urandom());
            end else if (r < 82) begin
                if (span == 0) push_put(pool_base);
                else push_put(pool_base + 32'($urandom_range(32'(span - 1))));
            end else if (r < 90) begin
                push_put(pool_base + $urandom_range(live_chunks()) * pool_size);
            end else if (r < 93) begin
                push_put(pool_base - 32'd1);
            end else begin
                push_put($urandom());
            end
        end
    endfunction

    task automatic drain();
        while (cmd_pending.size() != 0 || start || result_expect.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [fcpa_pkg::CFG_IDX_W-1:0] idx,
                             logic [fcpa_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == fcpa_pkg::REG_BASE) begin
            pool_base = val[fcpa_pkg::BASE_W-1:0];
            restart_pool();
        end else if (idx == fcpa_pkg::REG_SIZE) begin
            pool_size = val[fcpa_pkg::SIZE_W-1:0];
            restart_pool();
        end else if (idx == fcpa_pkg::REG_COUNT) begin
            pool_count = val[fcpa_pkg::COUNT_W-1:0];
            restart_pool();
        end
    endtask

    // Upper bits beyond each register's width carry noise.
    task automatic set_pool(logic [31:0] base, logic [15:0] size, logic [8:0] count);
        logic [fcpa_pkg::CFG_DATA_W-1:0] v;
        write_reg(fcpa_pkg::REG_BASE, base);
        v = $urandom();
        v[fcpa_pkg::SIZE_W-1:0] = size;
        write_reg(fcpa_pkg::REG_SIZE, v);
        v = $urandom();
        v[fcpa_pkg::COUNT_W-1:0] = count;
        write_reg(fcpa_pkg::REG_COUNT, v);
    endtask

    // Driver: holds a transaction until it is taken, idles at random between them.
    always @(negedge i_clk) begin : driver
        fcpa_pkg::t_cmd_in nxt;
        logic              go;
        go  = 1'b0;
        nxt = '0;
        if (!(start && !cmd_taken)) begin
            if (cmd_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = cmd_pending.pop_front();
                go  = 1'b1;
            end
            start <= go;
            if (go) i_cmd <= nxt;
        end
        cmd_taken = 1'b0;
    end

    // Monitor: predicts on accept, checks each result strobe against the oldest expectation.
    always @(posedge i_clk) begin : monitor
        fcpa_pkg::t_result want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid) begin
                if (result_expect.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: status=%0d addr=%h free=%0d",
                                 o_result.status, o_result.granted_address,
                                 o_result.free_count);
                end else begin
                    want = result_expect.pop_front();
                    if (o_result.status !== want.status ||
                        o_result.granted_address !== want.granted_address ||
                        o_result.free_count !== want.free_count) begin
                        err_count++;
                        if (err_count <= 10)
                            $display({"mismatch: exp status=%0d addr=%h free=%0d, ",
                                      "got status=%0d addr=%h free=%0d"},
                                     want.status, want.granted_address, want.free_count,
                                     o_result.status, o_result.granted_address,
                                     o_result.free_count);
                    end
                end
            end
            if (start && !busy) begin
                result_expect.push_back(apply_command(i_cmd));
                cmd_taken = 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] base;
        logic [15:0] size;
        int unsigned count_plan [RAND_PHASES];
        count_plan = '{3, 256, 1, 17, 300, 2, 511, 8};
        idle_pct = 0;
        restart_pool();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: range edges, full pool, ignored address on get
        push_get(32'hFFFF_FFFF);
        push_get(32'h0);
        push_put(32'h0);
        push_put(32'd16383);
        push_put(32'd64);
        push_put(32'd16384);
        push_put(32'hFFFF_FFFF);
        drain();

        // zero count: always empty, every put rejected
        set_pool(32'h0000_1000, 16'd16, 9'd0);
        push_get(32'h0);
        push_put(32'h0000_1000);
        drain();

        // zero size: every initial address equals the base, range is empty
        set_pool(32'h1234_5678, 16'd0, 9'd4);
        push_get(32'h0);
        push_get(32'h0);
        push_put(32'h1234_5678);
        drain();

        // addresses wrap past the top; range test uses the offset from base
        set_pool(32'hFFFF_FF00, 16'h0080, 9'd4);
        repeat (4) push_get(32'h0);
        push_put(32'hFFFF_FF00);
        push_put(32'h0000_0000);
        push_put(32'hFFFF_FFFF);
        drain();
        // unused register index leaves the pool as it is
        write_reg(REG_SPARE, $urandom());
        push_get(32'h0);
        drain();

        // count above depth behaves as full depth
        set_pool(32'h0, 16'd1, 9'd511);
        push_get(32'h0);
        push_put(32'd255);
        push_put(32'd256);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p % 4)
                0: base = $urandom();
                1: base = 32'h0;
                2: base = 32'hFFFF_FFFF;
                default: base = 32'hFFFF_F000 + $urandom_range(4095);
            endcase
            case (p)
                0: size = 16'd1;
                1, 5: size = 16'hFFFF;
                3: size = 16'($urandom_range(2, 300));
                default: size = 16'($urandom_range(1, 600));
            endcase
            set_pool(base, size, 9'(count_plan[p]));
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 77;
                default: idle_pct = 29;
            endcase
            push_random(PHASE_ITEMS);
            drain();
        end

        repeat (8) @(negedge i_clk);
        err_count += result_expect.size();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
